FILE: hw/rtl/oldq_pkg.sv
// oldq_pkg: shared constants, codes and payload types of the ordered list deque
// no dependencies; compiled first

package oldq_pkg;

  // default sizing of the list
  localparam int DepthDef     = 16;
  localparam int ElemWidthDef = 32;

  // fixed widths of the request and response fields
  localparam int OpW      = 3;
  localparam int PosW     = 5;
  localparam int ValW     = 32;
  localparam int StatusW  = 2;
  localparam int CountW   = 5;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT_AT  = 3'd4,
    OP_REMOVE_AT  = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // what every slot does at a clock edge
  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_INS,
    SHIFT_DEL
  } shift_mode_e;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic [PosW-1:0] position;
    logic [ValW-1:0] element_value;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValW-1:0]    removed_value;
    logic [CountW-1:0]  entry_count;
    logic               is_empty;
  } rsp_t;

endpackage

FILE: hw/rtl/oldq_if.sv
// oldq_req_if, oldq_rsp_if: valid/ready channels for requests and responses
// depends on oldq_pkg for the payload types

interface oldq_req_if import oldq_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface oldq_rsp_if import oldq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/oldq_cell.sv
// oldq_cell: one slot of the list, shifts toward either neighbor or loads new data
// depends on oldq_pkg for the shift mode

module oldq_cell import oldq_pkg::*; #(
  parameter int ElemWidth = ElemWidthDef,
  parameter int IdxW      = 4,
  parameter int CellIdx   = 0
) (
  input  logic                 clk_i,
  input  shift_mode_e          mode_i,
  input  logic [IdxW-1:0]      idx_i,
  input  logic [ElemWidth-1:0] left_i,
  input  logic [ElemWidth-1:0] right_i,
  input  logic [ElemWidth-1:0] new_i,
  output logic [ElemWidth-1:0] slot_o,
  output logic [ElemWidth-1:0] pick_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic [ElemWidth-1:0] slot_d, slot_q;

  always_comb begin
    slot_d = slot_q;
    case (mode_i)
      SHIFT_INS: begin
        if (MyIdx > idx_i) begin
          slot_d = left_i;
        end else if (MyIdx == idx_i) begin
          slot_d = new_i;
        end
      end
      SHIFT_DEL: begin
        if (MyIdx >= idx_i) begin
          slot_d = right_i;
        end
      end
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;
  // only the addressed slot drives the removal bus
  assign pick_o = (MyIdx == idx_i) ? slot_q : '0;

endmodule

FILE: hw/rtl/oldq_ctrl.sv
// oldq_ctrl: request decode, element count, status and the response register
// depends on oldq_pkg and the channel interfaces in oldq_if

module oldq_ctrl import oldq_pkg::*; #(
  parameter int Depth     = DepthDef,
  parameter int ElemWidth = ElemWidthDef,
  parameter int IdxW      = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  oldq_req_if.sink             req_i,
  oldq_rsp_if.source           rsp_o,
  output shift_mode_e          mode_o,
  output logic [IdxW-1:0]      idx_o,
  output logic [ElemWidth-1:0] new_value_o,
  input  logic [ElemWidth-1:0] removed_i
);

  localparam int CntW = $clog2(Depth + 1);
  localparam int CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [CntW-1:0] count_d, count_q;
  logic            rsp_valid_q;
  rsp_t            rsp_d, rsp_q;

  logic            fire;
  logic            full, empty;
  logic [CmpW-1:0] pos_ext, cnt_ext;
  status_e         status;
  shift_mode_e     op_mode;
  logic [IdxW-1:0] op_idx;

  assign full    = (count_q == CntFull);
  assign empty   = (count_q == '0);
  assign pos_ext = CmpW'(req_i.payload.position);
  assign cnt_ext = CmpW'(count_q);

  // response register frees up whenever its content is taken
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  always_comb begin
    status  = ST_OK;
    op_mode = SHIFT_HOLD;
    op_idx  = '0;
    case (req_i.payload.operation)
      OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op_mode = SHIFT_INS;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op_mode = SHIFT_INS;
          op_idx  = IdxW'(count_q);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          op_mode = SHIFT_DEL;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          op_mode = SHIFT_DEL;
          op_idx  = IdxW'(count_q - 1'b1);
        end
      end
      OP_INSERT_AT: begin
        if (full) begin
          status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status = ST_BAD_INDEX;
        end else begin
          op_mode = SHIFT_INS;
          op_idx  = IdxW'(req_i.payload.position);
        end
      end
      OP_REMOVE_AT: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_BAD_INDEX;
        end else begin
          op_mode = SHIFT_DEL;
          op_idx  = IdxW'(req_i.payload.position);
        end
      end
      default: status = ST_BAD_INDEX;
    endcase
  end

  assign mode_o      = fire ? op_mode : SHIFT_HOLD;
  assign idx_o       = op_idx;
  assign new_value_o = ElemWidth'(req_i.payload.element_value);

  always_comb begin
    count_d = count_q;
    case (op_mode)
      SHIFT_INS: count_d = count_q + 1'b1;
      SHIFT_DEL: count_d = count_q - 1'b1;
      default:   count_d = count_q;
    endcase
  end

  always_comb begin
    rsp_d.status        = status;
    rsp_d.removed_value = (op_mode == SHIFT_DEL) ? ValW'(removed_i) : '0;
    rsp_d.entry_count   = CountW'(count_d);
    rsp_d.is_empty      = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("element count above depth");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_o == SHIFT_INS |=> count_q == CntW'($past(count_q) + 1'b1))
    else $error("insert did not grow the count");

  a_del_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_o == SHIFT_DEL |=> count_q == CntW'($past(count_q) - 1'b1))
    else $error("remove did not shrink the count");

  a_fail_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.status != ST_OK |-> rsp_q.removed_value == '0)
    else $error("failed request reports a removed element");

  a_fail_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && status != ST_OK |=> $stable(count_q))
    else $error("failed request changed the count");
`endif

endmodule

FILE: hw/rtl/ordered_list_deque.sv
// ordered_list_deque: bounded ordered list with deque and indexed access
// depends on oldq_pkg, oldq_if, oldq_cell and oldq_ctrl
//
// Holds up to Depth elements, front first, in a row of slot cells. Every
// request is one of push front, push back, pop front, pop back, insert at
// an index (0 up to the count) or remove at an index (below the count), and
// gives exactly one response with a status (ok, empty, invalid index, full),
// the removed element (zero unless a pop or remove succeeded), the count
// afterwards and an empty flag. Each request is handled in place:
// every cell compares its own index with the target index and in the same
// clock either holds, takes its left neighbor (insert), takes its right
// neighbor (remove) or loads the new element, so the whole row shifts at
// once. The response sits in an output register, so a request is taken in
// every cycle in which that register is free or being emptied; throughput is
// one request per cycle while responses are taken, and the response to a
// request is presented in the cycle after it is taken. No clearing pass is
// needed after reset: only slots below the count are ever read.

module ordered_list_deque import oldq_pkg::*; #(
  parameter int Depth     = DepthDef,
  parameter int ElemWidth = ElemWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  oldq_req_if.sink    req_i,
  oldq_rsp_if.source  rsp_o
);

  localparam int IdxW = $clog2(Depth);

  shift_mode_e          mode;
  logic [IdxW-1:0]      idx;
  logic [ElemWidth-1:0] new_value;
  logic [ElemWidth-1:0] removed;
  logic [ElemWidth-1:0] slot [Depth];
  logic [ElemWidth-1:0] pick [Depth];

  // decode, count and response register
  oldq_ctrl #(
    .Depth     (Depth),
    .ElemWidth (ElemWidth),
    .IdxW      (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mode_o      (mode),
    .idx_o       (idx),
    .new_value_o (new_value),
    .removed_i   (removed)
  );

  // row of slots, cell 0 is the front of the list
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [ElemWidth-1:0] left_val, right_val;

    if (i == 0) begin : g_front
      assign left_val = '0;
    end else begin : g_inner_l
      assign left_val = slot[i-1];
    end

    // the last cell fills with zero when the row shifts toward the front
    if (i == Depth - 1) begin : g_back
      assign right_val = '0;
    end else begin : g_inner_r
      assign right_val = slot[i+1];
    end

    oldq_cell #(
      .ElemWidth (ElemWidth),
      .IdxW      (IdxW),
      .CellIdx   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .mode_i  (mode),
      .idx_i   (idx),
      .left_i  (left_val),
      .right_i (right_val),
      .new_i   (new_value),
      .slot_o  (slot[i]),
      .pick_o  (pick[i])
    );
  end

  // at most one cell drives its pick output, so an or collects the element
  always_comb begin
    removed = '0;
    for (int i = 0; i < Depth; i++) begin
      removed = removed | pick[i];
    end
  end

endmodule

FILE: bench/ordered_list_deque_test.sv
// ordered_list_deque_test: self-checking bench for the ordered list deque
// depends on oldq_pkg, oldq_if and the ordered_list_deque rtl

module ordered_list_deque_test import oldq_pkg::*; ();

  localparam int ListDepth   = DepthDef;
  localparam int RandomItems = 1200;

  // opcodes with no operation behind them, answered with invalid index
  localparam logic [OpW-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OpW-1:0] OP_UNUSED_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  oldq_req_if req_ch ();
  oldq_rsp_if rsp_ch ();

  ordered_list_deque dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  always #2 clk_i = ~clk_i;

  // bench copy of the list, front first, and responses still owed by the dut
  logic [ValW-1:0] list_contents[$];
  rsp_t            pending_rsp_q[$];
  int              error_count = 0;
  // set during the stretch where neither side holds back
  bit              steady_flow = 1'b0;

  // applies one request to the bench copy of the list and returns the
  // response the dut must give for it
  function automatic rsp_t apply_list_op(req_t item);
    rsp_t        r;
    int unsigned fill;
    fill            = list_contents.size();
    r.status        = ST_OK;
    r.removed_value = '0;
    case (item.operation)
      OP_PUSH_FRONT: begin
        if (fill >= ListDepth) r.status = ST_FULL;
        else list_contents.push_front(item.element_value);
      end
      OP_PUSH_BACK: begin
        if (fill >= ListDepth) r.status = ST_FULL;
        else list_contents.push_back(item.element_value);
      end
      OP_POP_FRONT: begin
        if (fill == 0) r.status = ST_EMPTY;
        else r.removed_value = list_contents.pop_front();
      end
      OP_POP_BACK: begin
        if (fill == 0) r.status = ST_EMPTY;
        else r.removed_value = list_contents.pop_back();
      end
      OP_INSERT_AT: begin
        // full wins over a bad index
        if (fill >= ListDepth) r.status = ST_FULL;
        else if (item.position > fill) r.status = ST_BAD_INDEX;
        else list_contents.insert(item.position, item.element_value);
      end
      OP_REMOVE_AT: begin
        // covers a remove on an empty list as well
        if (item.position >= fill) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.removed_value = list_contents[item.position];
          list_contents.delete(item.position);
        end
      end
      default: r.status = ST_BAD_INDEX;
    endcase
    r.entry_count = CountW'(list_contents.size());
    r.is_empty    = (list_contents.size() == 0);
    return r;
  endfunction

  function automatic req_t make_req(logic [OpW-1:0] op, int unsigned pos,
                                    logic [ValW-1:0] val);
    req_t r;
    r.operation     = op;
    r.position      = PosW'(pos);
    r.element_value = val;
    return r;
  endfunction

  // drives one request from the falling edge, at times after an idle gap, holds
  // it until the dut takes it, then books the expected response
  task automatic send_request(input req_t item);
    int gap;
    if (!steady_flow && $urandom_range(99) < 13) begin
      gap = $urandom_range(1, 3);
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid   <= 1'b1;
    req_ch.payload <= item;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    pending_rsp_q.push_back(apply_list_op(item));
  endtask

  // response side stalls at random except in the steady stretch
  always @(negedge clk_i) begin
    rsp_ch.ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 13);
  end

  task automatic compare_field(input string field, input logic [ValW-1:0] want,
                               input logic [ValW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      error_count++;
    end
  endtask

  // every response taken is matched against the oldest booked one
  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: response with none expected, expected nothing actual %h",
                 $time, rsp_ch.payload);
        error_count++;
      end else begin
        want = pending_rsp_q.pop_front();
        compare_field("status", ValW'(want.status), ValW'(rsp_ch.payload.status));
        compare_field("removed_value", want.removed_value,
                      rsp_ch.payload.removed_value);
        compare_field("entry_count", ValW'(want.entry_count),
                      ValW'(rsp_ch.payload.entry_count));
        compare_field("is_empty", ValW'(want.is_empty),
                      ValW'(rsp_ch.payload.is_empty));
      end
    end
  end

  // error cases on a list with nothing in it
  task automatic test_empty_list();
    send_request(make_req(OP_POP_FRONT, 0, 32'h0));
    send_request(make_req(OP_POP_BACK, 31, 32'hffff_ffff));
    send_request(make_req(OP_REMOVE_AT, 0, 32'h0));
    send_request(make_req(OP_REMOVE_AT, 31, 32'h0));
    send_request(make_req(OP_INSERT_AT, 1, 32'h1234_5678));
    send_request(make_req(OP_UNUSED_LO, 0, 32'h0));
    send_request(make_req(OP_UNUSED_HI, 31, 32'hffff_ffff));
  endtask

  // every way of adding, then topping up to exactly full
  task automatic test_fill_list();
    send_request(make_req(OP_PUSH_BACK, 0, 32'h0000_0000));
    send_request(make_req(OP_PUSH_BACK, 31, 32'hffff_ffff));
    send_request(make_req(OP_PUSH_FRONT, 0, 32'h5555_5555));
    send_request(make_req(OP_INSERT_AT, 1, 32'haaaa_aaaa));
    // insert at the count appends at the back
    send_request(make_req(OP_INSERT_AT, list_contents.size(), 32'h8000_0001));
    send_request(make_req(OP_INSERT_AT, 0, 32'h7fff_fffe));
    // index one past the end
    send_request(make_req(OP_INSERT_AT, list_contents.size() + 1, 32'h0));
    send_request(make_req(OP_REMOVE_AT, list_contents.size(), 32'h0));
    while (list_contents.size() < ListDepth)
      send_request(make_req(OP_INSERT_AT, $urandom_range(list_contents.size()),
                            $urandom));
  endtask

  // full list refuses every add, then the ends come off
  task automatic test_full_list();
    send_request(make_req(OP_PUSH_FRONT, 0, 32'hdead_beef));
    send_request(make_req(OP_PUSH_BACK, 0, 32'hdead_beef));
    send_request(make_req(OP_INSERT_AT, 3, 32'hdead_beef));
    // full must be reported ahead of the bad index
    send_request(make_req(OP_INSERT_AT, 31, 32'hdead_beef));
    send_request(make_req(OP_REMOVE_AT, ListDepth, 32'h0));
    send_request(make_req(OP_REMOVE_AT, ListDepth - 1, 32'h0));
    send_request(make_req(OP_POP_FRONT, 16, 32'h0));
    send_request(make_req(OP_POP_BACK, 0, 32'h0));
  endtask

  // random traffic in bursts that lean toward growing, shrinking or neither,
  // so the list swings between empty and full many times
  task automatic test_random_traffic();
    int              trend;
    int              grow_share;
    int              roll;
    int unsigned     fill;
    logic [OpW-1:0]  op;
    int unsigned     pos;
    logic [ValW-1:0] val;
    trend = 2;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) trend = $urandom_range(2);
      steady_flow = (n >= 400 && n < 700);
      grow_share  = (trend == 0) ? 70 : (trend == 1) ? 30 : 50;
      fill        = list_contents.size();
      roll        = $urandom_range(99);
      if (roll < 2) begin
        op = (roll == 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
      end else if ($urandom_range(99) < grow_share) begin
        case ($urandom_range(2))
          0:       op = OP_PUSH_FRONT;
          1:       op = OP_PUSH_BACK;
          default: op = OP_INSERT_AT;
        endcase
      end else begin
        case ($urandom_range(2))
          0:       op = OP_POP_FRONT;
          1:       op = OP_POP_BACK;
          default: op = OP_REMOVE_AT;
        endcase
      end
      // mostly legal indexes, sometimes anything the field holds
      if (op == OP_INSERT_AT && $urandom_range(9) < 8)
        pos = $urandom_range(fill);
      else if (op == OP_REMOVE_AT && fill > 0 && $urandom_range(9) < 8)
        pos = $urandom_range(fill - 1);
      else
        pos = $urandom_range(31);
      case ($urandom_range(9))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom;
      endcase
      send_request(make_req(op, pos, val));
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_fill_list();
    test_full_list();
    test_random_traffic();

    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    // drain outstanding responses, then keep watching for strays before the verdict
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ordered_list_deque_test: clean");
    end else begin
      $display("ordered_list_deque_test: errors");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #2000000;
    $display("ordered_list_deque_test: errors");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/oldq_pkg.sv
hw/rtl/oldq_if.sv
hw/rtl/oldq_cell.sv
hw/rtl/oldq_ctrl.sv
hw/rtl/ordered_list_deque.sv
bench/ordered_list_deque_test.sv
